// ===== hw/rtl/thumb_extension_insn_executor_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the Thumb extension instruction executor
// Concurrent property helpers, clocked and held off during reset.
// ----------------------------------------------------------------------------
`ifndef THUMB_EXTENSION_INSN_EXECUTOR_TOP_ASSERT_SVH
`define THUMB_EXTENSION_INSN_EXECUTOR_TOP_ASSERT_SVH

// same-cycle implication
`define TEI_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tei: same-cycle property failed");

// next-cycle implication
`define TEI_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tei: next-cycle property failed");

`endif

// ===== hw/rtl/tei_pkg.sv =====
// ----------------------------------------------------------------------------
// tei_pkg
// Types and encoding constants for the Thumb extension instruction executor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tei_pkg;

   typedef enum logic [2:0] {
      KIND_NONE       = 3'd0,
      KIND_SELECT     = 3'd1,
      KIND_BARRIER    = 3'd2,
      KIND_LOOP_START = 3'd3,
      KIND_LOOP_END   = 3'd4
   } kind_type;

   typedef enum logic [3:0] {
      COND_EQ = 4'h0, COND_NE = 4'h1, COND_CS = 4'h2, COND_CC = 4'h3,
      COND_MI = 4'h4, COND_PL = 4'h5, COND_VS = 4'h6, COND_VC = 4'h7,
      COND_HI = 4'h8, COND_LS = 4'h9, COND_GE = 4'hA, COND_LT = 4'hB,
      COND_GT = 4'hC, COND_LE = 4'hD, COND_AL = 4'hE, COND_NV = 4'hF
   } cond_type;

   typedef enum logic [1:0] {
      OP_CSEL  = 2'd0,
      OP_CSINC = 2'd1,
      OP_CSINV = 2'd2,
      OP_CSNEG = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      BAR_DSB = 4'h4,
      BAR_DMB = 4'h5,
      BAR_ISB = 4'h6
   } barrier_type;

   localparam logic [11:0] SEL_HW1_TOP   = 12'hEA5;
   localparam logic [1:0]  SEL_HW2_TOP   = 2'b10;
   localparam logic [15:0] BAR_HW1       = 16'hF3BF;
   localparam logic [7:0]  BAR_HW2_TOP   = 8'h8F;
   localparam logic [11:0] DLS_HW1_TOP   = 12'hF04;
   localparam logic [15:0] DLS_HW2       = 16'hE001;
   localparam logic [15:0] LE_HW1        = 16'hF00F;
   localparam logic [3:0]  LE_HW2_TOP    = 4'hC;
   localparam logic [3:0]  REG_SP        = 4'd13;
   localparam logic [3:0]  REG_PC        = 4'd15;
   localparam logic [3:0]  REG_LR        = 4'd14;
   localparam logic [31:0] INSN_BYTES    = 32'd4;

   typedef struct packed {
      logic [15:0] first_halfword;
      logic [15:0] second_halfword;
      logic [31:0] insn_address;
      logic [3:0]  flags_nzcv;
      logic [31:0] operand_n;
      logic [31:0] operand_m;
      logic [31:0] link_value;
   } req_type;

   typedef struct packed {
      logic        handled;
      kind_type    insn_kind;
      logic        write_enable;
      logic [3:0]  write_index;
      logic [31:0] write_value;
      logic [31:0] next_address;
   } rsp_type;

endpackage

`default_nettype wire

// ===== hw/rtl/tei_if.sv =====
// ----------------------------------------------------------------------------
// tei_if
// Valid/ready channels for instruction requests and execution results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface tei_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] first_halfword;
   logic [15:0] second_halfword;
   logic [31:0] insn_address;
   logic [3:0]  flags_nzcv;
   logic [31:0] operand_n;
   logic [31:0] operand_m;
   logic [31:0] link_value;

   modport source (
      output valid, first_halfword, second_halfword, insn_address, flags_nzcv,
             operand_n, operand_m, link_value,
      input  ready
   );
   modport sink (
      input  valid, first_halfword, second_halfword, insn_address, flags_nzcv,
             operand_n, operand_m, link_value,
      output ready
   );
endinterface

interface tei_rsp_if;
   logic        valid;
   logic        ready;
   logic        handled;
   logic [2:0]  insn_kind;
   logic        write_enable;
   logic [3:0]  write_index;
   logic [31:0] write_value;
   logic [31:0] next_address;

   modport source (
      output valid, handled, insn_kind, write_enable, write_index, write_value,
             next_address,
      input  ready
   );
   modport sink (
      input  valid, handled, insn_kind, write_enable, write_index, write_value,
             next_address,
      output ready
   );
endinterface

`default_nettype wire

// ===== hw/rtl/thumb_extension_insn_executor_top.sv =====
// Path: a request transfer goes through the input register, then the result
//   register, before the earliest result transfer.
// Throughput: one instruction per cycle while rsp_ch is ready; decode and ALU
//   select sit in a single combinational pass between the two registers.
// Reset: synchronous, active high; clears both valid flags, payload untouched.
// ----------------------------------------------------------------------------
// thumb_extension_insn_executor_top
// Two-register pipeline around the conditional-select / barrier / loop decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "thumb_extension_insn_executor_top_assert.svh"

module thumb_extension_insn_executor_top (
   input  var logic clock,
   input  var logic reset,
   tei_req_if.sink   req_ch,
   tei_rsp_if.source rsp_ch
);

   logic             s1_valid_ff, s1_valid_in;
   tei_pkg::req_type s1_data_ff, s1_data_in;
   logic             s1_ready;
   logic             s2_valid_ff, s2_valid_in;
   tei_pkg::rsp_type s2_data_ff, s2_data_in;
   logic             s2_ready;
   tei_pkg::rsp_type exec_rsp;

   assign s2_ready = !s2_valid_ff || rsp_ch.ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign req_ch.ready = s1_ready;

   always_comb begin
      s1_valid_in = s1_ready ? req_ch.valid : s1_valid_ff;
      s1_data_in  = s1_data_ff;
      if (req_ch.valid && s1_ready) begin
         s1_data_in.first_halfword  = req_ch.first_halfword;
         s1_data_in.second_halfword = req_ch.second_halfword;
         s1_data_in.insn_address    = req_ch.insn_address;
         s1_data_in.flags_nzcv      = req_ch.flags_nzcv;
         s1_data_in.operand_n       = req_ch.operand_n;
         s1_data_in.operand_m       = req_ch.operand_m;
         s1_data_in.link_value      = req_ch.link_value;
      end
   end

   tei_exec u_exec (
      .req (s1_data_ff),
      .rsp (exec_rsp)
   );

   always_comb begin
      s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;
      s2_data_in  = (s1_valid_ff && s2_ready) ? exec_rsp : s2_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_data_ff <= s1_data_in;
      s2_data_ff <= s2_data_in;
   end

   assign rsp_ch.valid        = s2_valid_ff;
   assign rsp_ch.handled      = s2_data_ff.handled;
   assign rsp_ch.insn_kind    = s2_data_ff.insn_kind;
   assign rsp_ch.write_enable = s2_data_ff.write_enable;
   assign rsp_ch.write_index  = s2_data_ff.write_index;
   assign rsp_ch.write_value  = s2_data_ff.write_value;
   assign rsp_ch.next_address = s2_data_ff.next_address;

   // a transfer in lands in the input register
   `TEI_ASSERT_NXT(a_req_lands, clock, reset, req_ch.valid && req_ch.ready, s1_valid_ff)
   // an occupied input register advancing always produces a result
   `TEI_ASSERT_NXT(a_s1_advances, clock, reset, s1_valid_ff && s2_ready, s2_valid_ff)
   // unrecognised instructions never write a register
   `TEI_ASSERT_IMP(a_unhandled_quiet, clock, reset, s2_valid_ff && !s2_data_ff.handled,
      !s2_data_ff.write_enable && (s2_data_ff.insn_kind == tei_pkg::KIND_NONE))
   // loop ops always target LR
   `TEI_ASSERT_IMP(a_loop_lr, clock, reset,
      s2_valid_ff && ((s2_data_ff.insn_kind == tei_pkg::KIND_LOOP_START) ||
                      (s2_data_ff.insn_kind == tei_pkg::KIND_LOOP_END)),
      s2_data_ff.write_enable && (s2_data_ff.write_index == tei_pkg::REG_LR))

endmodule

`default_nettype wire

// ===== hw/rtl/tei_cond_check.sv =====
// ----------------------------------------------------------------------------
// tei_cond_check
// Evaluates a 4-bit condition code against the NZCV flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tei_cond_check (
   input  var tei_pkg::cond_type cond,
   input  var logic [3:0]        nzcv,
   output var logic              pass
);

   logic n, z, c, v;

   assign n = nzcv[3];
   assign z = nzcv[2];
   assign c = nzcv[1];
   assign v = nzcv[0];

   always_comb begin
      unique case (cond)
         tei_pkg::COND_EQ: pass = z;
         tei_pkg::COND_NE: pass = !z;
         tei_pkg::COND_CS: pass = c;
         tei_pkg::COND_CC: pass = !c;
         tei_pkg::COND_MI: pass = n;
         tei_pkg::COND_PL: pass = !n;
         tei_pkg::COND_VS: pass = v;
         tei_pkg::COND_VC: pass = !v;
         tei_pkg::COND_HI: pass = c && !z;
         tei_pkg::COND_LS: pass = !c || z;
         tei_pkg::COND_GE: pass = (n == v);
         tei_pkg::COND_LT: pass = (n != v);
         tei_pkg::COND_GT: pass = !z && (n == v);
         tei_pkg::COND_LE: pass = z || (n != v);
         // NV behaves as AL here
         tei_pkg::COND_AL,
         tei_pkg::COND_NV: pass = 1'b1;
         default:          pass = 1'b1;
      endcase
   end

endmodule

`default_nettype wire

// ===== hw/rtl/tei_exec.sv =====
// ----------------------------------------------------------------------------
// tei_exec
// Decodes one registered instruction and forms its register write and next PC.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tei_exec (
   input  var tei_pkg::req_type req,
   output var tei_pkg::rsp_type rsp
);

   logic [15:0] hw1, hw2;
   logic [3:0]  rn, rd, rm;
   logic        rsvd;
   logic        cond_pass;
   logic        sel_hit, bar_hit, dls_hit, le_hit;
   logic [31:0] pc_next_seq;
   logic [31:0] lr_dec;
   logic [31:0] le_offset;
   logic [31:0] le_target;
   logic [31:0] sel_value;
   tei_pkg::barrier_type bar_sub;

   assign hw1 = req.first_halfword;
   assign hw2 = req.second_halfword;
   assign rn  = hw1[3:0];
   assign rd  = hw2[11:8];
   assign rm  = hw2[3:0];

   assign rsvd = (rn == tei_pkg::REG_SP) || (rn == tei_pkg::REG_PC) ||
                 (rd == tei_pkg::REG_SP) || (rd == tei_pkg::REG_PC) ||
                 (rm == tei_pkg::REG_SP) || (rm == tei_pkg::REG_PC);

   tei_cond_check u_cond (
      .cond (tei_pkg::cond_type'(hw2[7:4])),
      .nzcv (req.flags_nzcv),
      .pass (cond_pass)
   );

   assign bar_sub = tei_pkg::barrier_type'(hw2[7:4]);

   assign sel_hit = (hw1[15:4] == tei_pkg::SEL_HW1_TOP) &&
                    (hw2[15:14] == tei_pkg::SEL_HW2_TOP) && !rsvd;
   assign bar_hit = (hw1 == tei_pkg::BAR_HW1) && (hw2[15:8] == tei_pkg::BAR_HW2_TOP) &&
                    ((bar_sub == tei_pkg::BAR_DSB) || (bar_sub == tei_pkg::BAR_DMB) ||
                     (bar_sub == tei_pkg::BAR_ISB));
   assign dls_hit = (hw1[15:4] == tei_pkg::DLS_HW1_TOP) && (hw2 == tei_pkg::DLS_HW2);
   assign le_hit  = (hw1 == tei_pkg::LE_HW1) && (hw2[15:12] == tei_pkg::LE_HW2_TOP);

   assign pc_next_seq = req.insn_address + tei_pkg::INSN_BYTES;
   assign lr_dec      = req.link_value - 32'd1;
   // backward offset: imm10 in bits 11:2, the lone bit in bit 1
   assign le_offset   = {20'd0, hw2[10:1], hw2[11], 1'b0};
   assign le_target   = (lr_dec != 32'd0) ? (pc_next_seq - le_offset) : pc_next_seq;

   always_comb begin
      if (cond_pass) begin
         sel_value = req.operand_n;
      end else begin
         unique case (tei_pkg::op_type'(hw2[13:12]))
            tei_pkg::OP_CSINC: sel_value = req.operand_m + 32'd1;
            tei_pkg::OP_CSINV: sel_value = ~req.operand_m;
            tei_pkg::OP_CSNEG: sel_value = 32'd0 - req.operand_m;
            tei_pkg::OP_CSEL:  sel_value = req.operand_m;
            default:           sel_value = req.operand_m;
         endcase
      end
   end

   always_comb begin
      rsp.handled      = 1'b1;
      rsp.insn_kind    = tei_pkg::KIND_NONE;
      rsp.write_enable = 1'b0;
      rsp.write_index  = 4'd0;
      rsp.write_value  = 32'd0;
      rsp.next_address = pc_next_seq;
      priority if (sel_hit) begin
         rsp.insn_kind    = tei_pkg::KIND_SELECT;
         rsp.write_enable = 1'b1;
         rsp.write_index  = rd;
         rsp.write_value  = sel_value;
      end else if (bar_hit) begin
         rsp.insn_kind    = tei_pkg::KIND_BARRIER;
      end else if (dls_hit) begin
         rsp.insn_kind    = tei_pkg::KIND_LOOP_START;
         rsp.write_enable = 1'b1;
         rsp.write_index  = tei_pkg::REG_LR;
         rsp.write_value  = req.operand_n;
      end else if (le_hit) begin
         rsp.insn_kind    = tei_pkg::KIND_LOOP_END;
         rsp.write_enable = 1'b1;
         rsp.write_index  = tei_pkg::REG_LR;
         rsp.write_value  = lr_dec;
         rsp.next_address = le_target;
      end else begin
         rsp.handled      = 1'b0;
         rsp.next_address = req.insn_address;
      end
   end

endmodule

`default_nettype wire

// ===== bench/tb_thumb_extension_insn_executor_top.sv =====
// ----------------------------------------------------------------------------
// Testbench for thumb_extension_insn_executor_top
// A directed table of instructions, then about 500 random ones, go through
// the request channel with random gaps on both sides. Every result is checked
// field by field against an in-order queue of predicted results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_thumb_extension_insn_executor_top;
   import tei_pkg::*;

   localparam int RANDOM_ITEMS  = 500;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 8;

   typedef struct {
      req_type stim;
      bit      typed;
      rsp_type want;
   } insn_row_type;

   logic clock = 1'b0;
   logic reset;

   tei_req_if req_bus ();
   tei_rsp_if rsp_bus ();

   thumb_extension_insn_executor_top uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   rsp_type      pending_results[$];
   insn_row_type dir_rows[$];
   int           fail_count      = 0;
   int           results_checked = 0;
   int           cycle_count     = 0;
   int           sink_hold       = 0;
   int           kind_tally[8];
   bit           sink_always_ready = 1'b0;
   int           item_idx;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic bit cond_met(cond_type c, logic [3:0] f);
      logic n, z, cy, v;
      n  = f[3];
      z  = f[2];
      cy = f[1];
      v  = f[0];
      case (c)
         COND_EQ: return z;
         COND_NE: return !z;
         COND_CS: return cy;
         COND_CC: return !cy;
         COND_MI: return n;
         COND_PL: return !n;
         COND_VS: return v;
         COND_VC: return !v;
         COND_HI: return cy && !z;
         COND_LS: return !cy || z;
         COND_GE: return n == v;
         COND_LT: return n != v;
         COND_GT: return !z && (n == v);
         COND_LE: return z || (n != v);
         default: return 1'b1;   // AL, and NV behaves the same
      endcase
   endfunction

   function automatic bit is_sp_or_pc(logic [3:0] r);
      return (r == REG_SP) || (r == REG_PC);
   endfunction

   function automatic rsp_type predict_exec(req_type q);
      rsp_type     r;
      logic [3:0]  rn, rd, rm;
      logic [31:0] sel, count, target;
      bit          done;
      r              = '0;
      r.insn_kind    = KIND_NONE;
      r.next_address = q.insn_address;
      done           = 1'b0;
      rn = q.first_halfword[3:0];
      rd = q.second_halfword[11:8];
      rm = q.second_halfword[3:0];

      if (q.first_halfword[15:4] == SEL_HW1_TOP && q.second_halfword[15:14] == SEL_HW2_TOP
          && !is_sp_or_pc(rn) && !is_sp_or_pc(rd) && !is_sp_or_pc(rm)) begin
         if (cond_met(cond_type'(q.second_halfword[7:4]), q.flags_nzcv)) begin
            sel = q.operand_n;
         end else begin
            case (op_type'(q.second_halfword[13:12]))
               OP_CSINC: sel = q.operand_m + 32'd1;
               OP_CSINV: sel = ~q.operand_m;
               OP_CSNEG: sel = 32'd0 - q.operand_m;
               default:  sel = q.operand_m;
            endcase
         end
         r.handled      = 1'b1;
         r.insn_kind    = KIND_SELECT;
         r.write_enable = 1'b1;
         r.write_index  = rd;
         r.write_value  = sel;
         r.next_address = q.insn_address + INSN_BYTES;
         done           = 1'b1;
      end

      if (!done && q.first_halfword == BAR_HW1 && q.second_halfword[15:8] == BAR_HW2_TOP
          && (q.second_halfword[7:4] == BAR_DSB || q.second_halfword[7:4] == BAR_DMB
              || q.second_halfword[7:4] == BAR_ISB)) begin
         r.handled      = 1'b1;
         r.insn_kind    = KIND_BARRIER;
         r.next_address = q.insn_address + INSN_BYTES;
         done           = 1'b1;
      end

      if (!done && q.first_halfword[15:4] == DLS_HW1_TOP && q.second_halfword == DLS_HW2) begin
         r.handled      = 1'b1;
         r.insn_kind    = KIND_LOOP_START;
         r.write_enable = 1'b1;
         r.write_index  = REG_LR;
         r.write_value  = q.operand_n;
         r.next_address = q.insn_address + INSN_BYTES;
         done           = 1'b1;
      end

      if (!done && q.first_halfword == LE_HW1 && q.second_halfword[15:12] == LE_HW2_TOP) begin
         count  = q.link_value - 32'd1;
         target = q.insn_address + INSN_BYTES;
         // branch back unless the counter has just reached zero
         if (count != 32'd0)
            target = target - ({q.second_halfword[10:1], 2'b00} | {q.second_halfword[11], 1'b0});
         r.handled      = 1'b1;
         r.insn_kind    = KIND_LOOP_END;
         r.write_enable = 1'b1;
         r.write_index  = REG_LR;
         r.write_value  = count;
         r.next_address = target;
      end
      return r;
   endfunction

   // ------------------------------------------------------------ construction

   function automatic req_type mk_req(logic [15:0] h1, logic [15:0] h2, logic [31:0] pc,
                                      logic [3:0] f, logic [31:0] vn, logic [31:0] vm,
                                      logic [31:0] lr);
      req_type q;
      q.first_halfword  = h1;
      q.second_halfword = h2;
      q.insn_address    = pc;
      q.flags_nzcv      = f;
      q.operand_n       = vn;
      q.operand_m       = vm;
      q.link_value      = lr;
      return q;
   endfunction

   function automatic rsp_type mk_rsp(bit h, kind_type k, bit we, logic [3:0] idx,
                                      logic [31:0] val, logic [31:0] nxt);
      rsp_type r;
      r.handled      = h;
      r.insn_kind    = k;
      r.write_enable = we;
      r.write_index  = idx;
      r.write_value  = val;
      r.next_address = nxt;
      return r;
   endfunction

   function automatic logic [15:0] sel_hw2(op_type op, logic [3:0] rd, cond_type c,
                                           logic [3:0] rm);
      return {SEL_HW2_TOP, op, rd, c, rm};
   endfunction

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 19))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         2:       return 32'h8000_0000;
         3:       return 32'h7FFF_FFFF;
         4:       return 32'h0000_0001;
         default: return $urandom;
      endcase
   endfunction

   // SP/PC kept rare so most select forms are taken
   function automatic logic [3:0] rand_sel_reg();
      logic [3:0] r;
      r = 4'($urandom_range(0, 15));
      if (is_sp_or_pc(r) && $urandom_range(0, 3) != 0)
         r = r - 4'd1;
      return r;
   endfunction

   function automatic int pick_gap();
      int unsigned p;
      p = $urandom_range(0, 99);
      if (p < 80)
         return $urandom_range(1, 3);
      else if (p < 95)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic req_type make_insn();
      req_type     q;
      int unsigned pick, cls;
      bit          near;
      logic [31:0] halves;
      q.insn_address = rand_word();
      q.flags_nzcv   = 4'($urandom);
      q.operand_n    = rand_word();
      q.operand_m    = rand_word();
      q.link_value   = ($urandom_range(0, 9) < 4) ? 32'($urandom_range(0, 2)) : rand_word();
      pick = $urandom_range(0, 99);
      cls  = (pick < 35) ? 0 : (pick < 45) ? 1 : (pick < 55) ? 2 : (pick < 75) ? 3 : 4;
      // half the noise is a proper encoding with one bit flipped
      near = (cls == 4) && ($urandom_range(0, 1) == 1);
      if (near)
         cls = $urandom_range(0, 3);
      case (cls)
         0: begin
            q.first_halfword  = {SEL_HW1_TOP, rand_sel_reg()};
            q.second_halfword = sel_hw2(op_type'($urandom_range(0, 3)), rand_sel_reg(),
                                        cond_type'($urandom_range(0, 15)), rand_sel_reg());
         end
         1: begin
            q.first_halfword  = BAR_HW1;
            q.second_halfword = {BAR_HW2_TOP,
                                 ($urandom_range(0, 6) != 0) ? 4'($urandom_range(4, 6))
                                                             : 4'($urandom),
                                 4'($urandom)};
         end
         2: begin
            q.first_halfword  = {DLS_HW1_TOP, 4'($urandom)};
            q.second_halfword = DLS_HW2;
         end
         3: begin
            q.first_halfword  = LE_HW1;
            q.second_halfword = {LE_HW2_TOP, 12'($urandom)};
         end
         default: begin
            q.first_halfword  = 16'($urandom);
            q.second_halfword = 16'($urandom);
         end
      endcase
      if (near) begin
         halves = {q.first_halfword, q.second_halfword} ^ (32'd1 << $urandom_range(0, 31));
         {q.first_halfword, q.second_halfword} = halves;
      end
      return q;
   endfunction

   // ------------------------------------------------------------------ sender

   task automatic send_insn(input req_type q, input bit typed, input rsp_type want,
                            input int gap);
      rsp_type e;
      req_bus.valid           <= 1'b1;
      req_bus.first_halfword  <= q.first_halfword;
      req_bus.second_halfword <= q.second_halfword;
      req_bus.insn_address    <= q.insn_address;
      req_bus.flags_nzcv      <= q.flags_nzcv;
      req_bus.operand_n       <= q.operand_n;
      req_bus.operand_m       <= q.operand_m;
      req_bus.link_value      <= q.link_value;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      e = typed ? want : predict_exec(q);
      pending_results.push_back(e);
      kind_tally[e.insn_kind]++;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // -------------------------------------------------------------------- sink

   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (sink_hold > 0 && !sink_always_ready) begin
            sink_hold--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            sink_hold = 0;
            if (!sink_always_ready && $urandom_range(0, 99) < 25)
               sink_hold = pick_gap();
         end
      end
   end

   // --------------------------------------------------------------- checking

   task automatic check_field(input string name, input logic [31:0] e, input logic [31:0] a);
      if (a !== e) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, e, a);
         fail_count++;
      end
   endtask

   task automatic check_result(input rsp_type e);
      check_field("handled",      e.handled,      rsp_bus.handled);
      check_field("insn_kind",    e.insn_kind,    rsp_bus.insn_kind);
      check_field("write_enable", e.write_enable, rsp_bus.write_enable);
      check_field("write_index",  e.write_index,  rsp_bus.write_index);
      check_field("write_value",  e.write_value,  rsp_bus.write_value);
      check_field("next_address", e.next_address, rsp_bus.next_address);
      results_checked++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_results.size() == 0) begin
            $error("result transfer with no instruction outstanding");
            fail_count++;
         end else begin
            check_result(pending_results.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_results.size());
         $display("status: fail");
         $finish;
      end
   end

   // -------------------------------------------------------------------- main

   initial begin
      reset                   = 1'b1;
      req_bus.valid           = 1'b0;
      req_bus.first_halfword  = '0;
      req_bus.second_halfword = '0;
      req_bus.insn_address    = '0;
      req_bus.flags_nzcv      = '0;
      req_bus.operand_n       = '0;
      req_bus.operand_m       = '0;
      req_bus.link_value      = '0;
      foreach (kind_tally[k]) kind_tally[k] = 0;

      // unrecognised extremes: PC unchanged
      dir_rows.push_back('{mk_req(16'h0000, 16'h0000, 32'h0000_1000, 4'h0, '0, '0, '0), 1'b1,
                           mk_rsp(0, KIND_NONE, 0, 4'd0, 32'd0, 32'h0000_1000)});
      dir_rows.push_back('{mk_req(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 4'hF, '1, '1, '1), 1'b1,
                           mk_rsp(0, KIND_NONE, 0, 4'd0, 32'd0, 32'hFFFF_FFFF)});
      // selects, all four ops, passing and failing conditions
      dir_rows.push_back('{mk_req({SEL_HW1_TOP, 4'd1}, sel_hw2(OP_CSEL, 4'd2, COND_EQ, 4'd3),
                                  32'h0000_2000, 4'b0100, 32'h1111_1111, 32'h2222_2222, '0),
                           1'b0, '0});
      dir_rows.push_back('{mk_req({SEL_HW1_TOP, 4'd1}, sel_hw2(OP_CSEL, 4'd2, COND_EQ, 4'd3),
                                  32'h0000_2000, 4'b0000, 32'h1111_1111, 32'h2222_2222, '0),
                           1'b0, '0});
      dir_rows.push_back('{mk_req({SEL_HW1_TOP, 4'd0}, sel_hw2(OP_CSINC, 4'd14, COND_NE, 4'd12),
                                  32'h0000_3000, 4'b0100, 32'h0, 32'hFFFF_FFFF, '0),
                           1'b0, '0});
      dir_rows.push_back('{mk_req({SEL_HW1_TOP, 4'd12}, sel_hw2(OP_CSINV, 4'd0, COND_GE, 4'd14),
                                  32'h0000_3004, 4'b1000, 32'h5, 32'h0, '0),
                           1'b0, '0});
      dir_rows.push_back('{mk_req({SEL_HW1_TOP, 4'd14}, sel_hw2(OP_CSNEG, 4'd7, COND_GT, 4'd0),
                                  32'hFFFF_FFFC, 4'b0100, 32'h5, 32'h8000_0000, '0),
                           1'b0, '0});
      // condition fifteen holds always, same as AL
      dir_rows.push_back('{mk_req({SEL_HW1_TOP, 4'd4}, sel_hw2(OP_CSNEG, 4'd5, COND_NV, 4'd6),
                                  32'h0000_4000, 4'b0000, 32'hCAFE_0001, 32'h1, '0),
                           1'b0, '0});
      dir_rows.push_back('{mk_req({SEL_HW1_TOP, 4'd4}, sel_hw2(OP_CSINC, 4'd5, COND_AL, 4'd6),
                                  32'h0000_4004, 4'b1111, 32'hCAFE_0002, 32'h1, '0),
                           1'b0, '0});
      dir_rows.push_back('{mk_req({SEL_HW1_TOP, 4'd8}, sel_hw2(OP_CSINV, 4'd9, COND_HI, 4'd10),
                                  32'h0000_4008, 4'b0010, 32'h0F0F_0F0F, 32'hF0F0_F0F0, '0),
                           1'b0, '0});
      dir_rows.push_back('{mk_req({SEL_HW1_TOP, 4'd8}, sel_hw2(OP_CSEL, 4'd9, COND_LE, 4'd10),
                                  32'h0000_400C, 4'b1000, 32'h0F0F_0F0F, 32'hF0F0_F0F0, '0),
                           1'b0, '0});
      // SP or PC as an operand, or a wrong second-halfword top, rejects the select form
      dir_rows.push_back('{mk_req({SEL_HW1_TOP, REG_SP}, sel_hw2(OP_CSEL, 4'd1, COND_AL, 4'd2),
                                  32'h0000_5000, 4'h0, '1, '1, '0), 1'b1,
                           mk_rsp(0, KIND_NONE, 0, 4'd0, 32'd0, 32'h0000_5000)});
      dir_rows.push_back('{mk_req({SEL_HW1_TOP, 4'd1}, sel_hw2(OP_CSEL, REG_PC, COND_AL, 4'd2),
                                  32'h0000_5004, 4'h0, '1, '1, '0), 1'b1,
                           mk_rsp(0, KIND_NONE, 0, 4'd0, 32'd0, 32'h0000_5004)});
      dir_rows.push_back('{mk_req({SEL_HW1_TOP, 4'd1}, sel_hw2(OP_CSEL, 4'd3, COND_AL, REG_SP),
                                  32'h0000_5008, 4'h0, '1, '1, '0), 1'b1,
                           mk_rsp(0, KIND_NONE, 0, 4'd0, 32'd0, 32'h0000_5008)});
      dir_rows.push_back('{mk_req({SEL_HW1_TOP, 4'd1},
                                  sel_hw2(OP_CSEL, 4'd3, COND_AL, 4'd4) | 16'h4000,
                                  32'h0000_500C, 4'h0, '1, '1, '0), 1'b1,
                           mk_rsp(0, KIND_NONE, 0, 4'd0, 32'd0, 32'h0000_500C)});
      // barriers are NOPs, including address wrap; an unknown option is unrecognised
      dir_rows.push_back('{mk_req(BAR_HW1, {BAR_HW2_TOP, BAR_DSB, 4'hF}, 32'h0000_2000,
                                  4'h0, '1, '1, '1), 1'b1,
                           mk_rsp(1, KIND_BARRIER, 0, 4'd0, 32'd0, 32'h0000_2004)});
      dir_rows.push_back('{mk_req(BAR_HW1, {BAR_HW2_TOP, BAR_DMB, 4'h0}, 32'h0000_0000,
                                  4'h0, '0, '0, '0), 1'b1,
                           mk_rsp(1, KIND_BARRIER, 0, 4'd0, 32'd0, 32'h0000_0004)});
      dir_rows.push_back('{mk_req(BAR_HW1, {BAR_HW2_TOP, BAR_ISB, 4'hF}, 32'hFFFF_FFFC,
                                  4'h0, '0, '0, '0), 1'b1,
                           mk_rsp(1, KIND_BARRIER, 0, 4'd0, 32'd0, 32'h0000_0000)});
      dir_rows.push_back('{mk_req(BAR_HW1, {BAR_HW2_TOP, 4'h7, 4'hF}, 32'h0000_2008,
                                  4'h0, '0, '0, '0), 1'b1,
                           mk_rsp(0, KIND_NONE, 0, 4'd0, 32'd0, 32'h0000_2008)});
      // loop start, and a near miss on its second halfword
      dir_rows.push_back('{mk_req({DLS_HW1_TOP, 4'd0}, DLS_HW2, 32'h0000_0100,
                                  4'h0, 32'hFFFF_FFFF, 32'h0, 32'h0), 1'b1,
                           mk_rsp(1, KIND_LOOP_START, 1, REG_LR, 32'hFFFF_FFFF, 32'h0000_0104)});
      dir_rows.push_back('{mk_req({DLS_HW1_TOP, 4'd3}, 16'hE000, 32'h0000_0100,
                                  4'h0, 32'h1234, 32'h0, 32'h0), 1'b1,
                           mk_rsp(0, KIND_NONE, 0, 4'd0, 32'd0, 32'h0000_0100)});
      // loop end: counter reaching zero falls through
      dir_rows.push_back('{mk_req(LE_HW1, {LE_HW2_TOP, 12'hFFF}, 32'h0000_0400,
                                  4'h0, '0, '0, 32'd1), 1'b1,
                           mk_rsp(1, KIND_LOOP_END, 1, REG_LR, 32'd0, 32'h0000_0404)});
      // LR of zero wraps and branches, largest offset, address wraps
      dir_rows.push_back('{mk_req(LE_HW1, {LE_HW2_TOP, 12'hFFE}, 32'h0000_0000,
                                  4'h0, '0, '0, 32'd0), 1'b0, '0});
      dir_rows.push_back('{mk_req(LE_HW1, {LE_HW2_TOP, 12'h002}, 32'h0000_1000,
                                  4'h0, '0, '0, 32'd2), 1'b0, '0});
      // offset bit 11 only, bit 0 ignored
      dir_rows.push_back('{mk_req(LE_HW1, {LE_HW2_TOP, 12'h801}, 32'h8000_0000,
                                  4'h0, '0, '0, 32'hFFFF_FFFF), 1'b0, '0});

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i])
         send_insn(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want,
                   ($urandom_range(0, 2) == 0) ? pick_gap() : 0);

      for (item_idx = 0; item_idx < RANDOM_ITEMS; item_idx++) begin
         // back-to-back stretch with the sink never stalling
         if (item_idx == 100)
            sink_always_ready = 1'b1;
         if (item_idx == 180)
            sink_always_ready = 1'b0;
         if (item_idx == 300) begin
            req_bus.valid <= 1'b0;
            do @(posedge clock); while (pending_results.size() != 0);
         end
         send_insn(make_insn(), 1'b0, '0,
                   (sink_always_ready || $urandom_range(0, 99) >= 30) ? 0 : pick_gap());
      end
      req_bus.valid <= 1'b0;

      sink_always_ready = 1'b1;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("%0d results checked from %0d table rows and %0d random instructions",
               results_checked, dir_rows.size(), RANDOM_ITEMS);
      $display("classes: none %0d, select %0d, barrier %0d, loop start %0d, loop end %0d",
               kind_tally[KIND_NONE], kind_tally[KIND_SELECT], kind_tally[KIND_BARRIER],
               kind_tally[KIND_LOOP_START], kind_tally[KIND_LOOP_END]);
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/tei_pkg.sv
hw/rtl/tei_if.sv
hw/rtl/tei_cond_check.sv
hw/rtl/tei_exec.sv
hw/rtl/thumb_extension_insn_executor_top.sv
bench/tb_thumb_extension_insn_executor_top.sv
